[hdl/srt_pkg.sv]
// ----------------------------------------------------------------------------
// srt_pkg
// Types and constants shared by the sorted region table and its cells.
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_DROP = 1'b1;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_ZERO     = 3'd1,
        STATUS_WRAP     = 3'd2,
        STATUS_FULL     = 3'd3,
        STATUS_OVERLAP  = 3'd4,
        STATUS_NOTFOUND = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        SHIFT_NONE   = 2'd0,
        SHIFT_INSERT = 2'd1,
        SHIFT_REMOVE = 2'd2
    } shift_op_t;

    // One stored region. The end address is kept instead of the length,
    // since the length is only ever used to form the end.
    typedef struct packed {
        logic [63:0] base;
        logic [63:0] end_addr;
        logic        kind;
        logic [7:0]  prot;
    } entry_t;

    // Request broadcast to every cell while it is being worked on.
    typedef struct packed {
        logic [63:0] base;
        logic [63:0] end_addr;
        logic        kind;
        logic [7:0]  prot;
    } req_t;

    // Record carried along the cell row: first hit of each kind so far.
    typedef struct packed {
        logic             ovl_found;
        logic [63:0]      ovl_base;
        logic             gt_found;
        logic [IDX_W-1:0] gt_idx;
        logic             eq_found;
        logic [IDX_W-1:0] eq_idx;
    } scan_t;

    typedef struct packed {
        shift_op_t        op;
        logic [IDX_W-1:0] pos;
    } shift_cmd_t;

endpackage

[hdl/srt_req_if.sv]
// ----------------------------------------------------------------------------
// srt_req_if
// Request channel of the sorted region table: add or drop one region.
// ----------------------------------------------------------------------------
interface srt_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] region_base;
    logic [63:0] region_size;
    logic        region_kind;
    logic [7:0]  protection;

    modport source (
        output valid, action, region_base, region_size, region_kind, protection,
        input  ready
    );

    modport sink (
        input  valid, action, region_base, region_size, region_kind, protection,
        output ready
    );
endinterface

[hdl/srt_rsp_if.sv]
// ----------------------------------------------------------------------------
// srt_rsp_if
// Result channel of the sorted region table: one result per request.
// ----------------------------------------------------------------------------
interface srt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [6:0]  entry_count;
    logic [63:0] conflict_base;

    modport source (
        output valid, status, slot, entry_count, conflict_base,
        input  ready
    );

    modport sink (
        input  valid, status, slot, entry_count, conflict_base,
        output ready
    );
endinterface

[hdl/sorted_region_table.sv]
// ----------------------------------------------------------------------------
// sorted_region_table
// Table of address regions kept sorted by base and pairwise disjoint, built
// as a row of cells that shift entries up on insert and down on removal.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Fields
//  req      in   action, region_base, region_size, region_kind, protection
//  rsp      out  status, slot, entry_count, conflict_base
//
// A request that is searched passes through the check, the search and the update
// states to a valid result: the first-hit record walks the cell row one cell a cycle.
// An add with a zero size, a wrap or a full table is answered from the check state.
// Reset clears the state, both counters and output valid; slots are never read unwritten.
// A result waits in the output register while the next request is accepted;
// a second finished result is held until the first has been taken.
// ----------------------------------------------------------------------------
module sorted_region_table
    import srt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    srt_req_if.sink   req,
    srt_rsp_if.source rsp
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_SEARCH = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic             out_valid_reg, out_valid_next;

    req_t             req_reg, req_next;
    logic             action_reg, action_next;
    logic             zero_reg, zero_next;
    logic             wrap_reg, wrap_next;
    status_t          res_status_reg, res_status_next;
    logic [IDX_W-1:0] res_slot_reg, res_slot_next;
    logic [63:0]      res_conflict_reg, res_conflict_next;
    status_t          out_status_reg, out_status_next;
    logic [5:0]       out_slot_reg, out_slot_next;
    logic [6:0]       out_count_reg, out_count_next;
    logic [63:0]      out_conflict_reg, out_conflict_next;

    logic             req_fire;
    logic [64:0]      sum;
    shift_cmd_t       cmd;
    scan_t            scan_res;

    entry_t           cell_entry [TABLE_DEPTH];
    scan_t            scan_chain [TABLE_DEPTH+1];

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign sum       = {1'b0, req.region_base} + {1'b0, req.region_size};
    assign scan_res  = scan_chain[TABLE_DEPTH];

    assign scan_chain[0] = '0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        entry_t left_entry;
        entry_t right_entry;

        if (i == 0)
        begin : g_first
            assign left_entry = cell_entry[i];
        end
        else
        begin : g_left
            assign left_entry = cell_entry[i-1];
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_last
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_right
            assign right_entry = cell_entry[i+1];
        end

        srt_cell u_cell (
            .clk         (clk),
            .cell_index  (IDX_W'(i)),
            .count       (count_reg),
            .req         (req_reg),
            .cmd         (cmd),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .scan_in     (scan_chain[i]),
            .scan_out    (scan_chain[i+1])
        );
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        scan_cnt_next     = scan_cnt_reg;
        out_valid_next    = out_valid_reg;
        req_next          = req_reg;
        action_next       = action_reg;
        zero_next         = zero_reg;
        wrap_next         = wrap_reg;
        res_status_next   = res_status_reg;
        res_slot_next     = res_slot_reg;
        res_conflict_next = res_conflict_reg;
        out_status_next   = out_status_reg;
        out_slot_next     = out_slot_reg;
        out_count_next    = out_count_reg;
        out_conflict_next = out_conflict_reg;
        cmd.op            = SHIFT_NONE;
        cmd.pos           = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    req_next.base     = req.region_base;
                    req_next.end_addr = sum[63:0];
                    req_next.kind     = req.region_kind;
                    req_next.prot     = req.protection;
                    action_next       = req.action;
                    zero_next         = (req.region_size == 64'd0);
                    wrap_next         = sum[64];
                    state_next        = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                res_slot_next     = '0;
                res_conflict_next = '0;
                scan_cnt_next     = '0;
                res_status_next   = STATUS_OK;
                state_next        = ST_SEARCH;
                if (action_reg == ACT_ADD)
                begin
                    priority if (zero_reg)
                    begin
                        res_status_next = STATUS_ZERO;
                        state_next      = ST_DONE;
                    end
                    else if (wrap_reg)
                    begin
                        res_status_next = STATUS_WRAP;
                        state_next      = ST_DONE;
                    end
                    else if (count_reg == CNT_W'(TABLE_DEPTH))
                    begin
                        res_status_next = STATUS_FULL;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                // The record advances one cell per cycle until it reaches the row's end.
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_DONE;
                if (action_reg == ACT_ADD)
                begin
                    if (scan_res.ovl_found)
                    begin
                        res_status_next   = STATUS_OVERLAP;
                        res_conflict_next = scan_res.ovl_base;
                    end
                    else
                    begin
                        cmd.op          = SHIFT_INSERT;
                        cmd.pos         = scan_res.gt_found ? scan_res.gt_idx
                                                            : IDX_W'(count_reg);
                        res_status_next = STATUS_OK;
                        res_slot_next   = cmd.pos;
                        count_next      = count_reg + 1'b1;
                    end
                end
                else
                begin
                    if (scan_res.eq_found)
                    begin
                        cmd.op          = SHIFT_REMOVE;
                        cmd.pos         = scan_res.eq_idx;
                        res_status_next = STATUS_OK;
                        res_slot_next   = scan_res.eq_idx;
                        count_next      = count_reg - 1'b1;
                    end
                    else
                    begin
                        res_status_next = STATUS_NOTFOUND;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next    = 1'b1;
                    out_status_next   = res_status_reg;
                    out_slot_next     = 6'(res_slot_reg);
                    out_count_next    = 7'(count_reg);
                    out_conflict_next = res_conflict_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg          <= req_next;
        action_reg       <= action_next;
        zero_reg         <= zero_next;
        wrap_reg         <= wrap_next;
        res_status_reg   <= res_status_next;
        res_slot_reg     <= res_slot_next;
        res_conflict_reg <= res_conflict_next;
        out_status_reg   <= out_status_next;
        out_slot_reg     <= out_slot_next;
        out_count_reg    <= out_count_next;
        out_conflict_reg <= out_conflict_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.slot          = out_slot_reg;
    assign rsp.entry_count   = out_count_reg;
    assign rsp.conflict_base = out_conflict_reg;

endmodule

[hdl/srt_cell.sv]
// ----------------------------------------------------------------------------
// srt_cell
// One table slot: holds a region, compares it with the current request and
// passes the first-hit record on to the next cell, one stage per cycle.
// ----------------------------------------------------------------------------
module srt_cell
    import srt_pkg::*;
(
    input  logic             clk,
    input  logic [IDX_W-1:0] cell_index,
    input  logic [CNT_W-1:0] count,
    input  req_t             req,
    input  shift_cmd_t       cmd,
    input  entry_t           left_entry,
    input  entry_t           right_entry,
    output entry_t           entry,
    input  scan_t            scan_in,
    output scan_t            scan_out
);

    entry_t entry_reg;
    entry_t entry_next;
    scan_t  scan_reg;
    scan_t  scan_next;

    logic occupied;
    logic hit_ovl;
    logic hit_gt;
    logic hit_eq;

    assign occupied = CNT_W'(cell_index) < count;
    assign hit_ovl  = occupied && (req.base < entry_reg.end_addr)
                               && (entry_reg.base < req.end_addr);
    assign hit_gt   = occupied && (entry_reg.base > req.base);
    assign hit_eq   = occupied && (entry_reg.base == req.base);

    always_comb
    begin
        scan_next = scan_in;
        if (!scan_in.ovl_found && hit_ovl)
        begin
            scan_next.ovl_found = 1'b1;
            scan_next.ovl_base  = entry_reg.base;
        end
        if (!scan_in.gt_found && hit_gt)
        begin
            scan_next.gt_found = 1'b1;
            scan_next.gt_idx   = cell_index;
        end
        if (!scan_in.eq_found && hit_eq)
        begin
            scan_next.eq_found = 1'b1;
            scan_next.eq_idx   = cell_index;
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.op)
            SHIFT_INSERT:
            begin
                if (cell_index > cmd.pos)
                begin
                    entry_next = left_entry;
                end
                else if (cell_index == cmd.pos)
                begin
                    entry_next.base     = req.base;
                    entry_next.end_addr = req.end_addr;
                    entry_next.kind     = req.kind;
                    entry_next.prot     = req.prot;
                end
            end
            SHIFT_REMOVE:
            begin
                if (cell_index >= cmd.pos)
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        scan_reg  <= scan_next;
    end

    assign entry    = entry_reg;
    assign scan_out = scan_reg;

endmodule
